// File: design/itoa_pkg.sv
// Shared constants, types and state encoding for the signed integer to decimal text unit.
package itoa_pkg;

    localparam int VALUE_BITS = 32;
    // Enough decimal digits for a magnitude of 2**(VALUE_BITS-1).
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift_up;
    } t_cell_ctrl;

endpackage

// File: design/signed_int_to_decimal_ascii_unit.sv
// Top level: signed integer to decimal ASCII text, built on a row of BCD digit cells.
//
// Request side: drive i_value and raise start; the request is taken at a rising
// edge where start is high and busy is low. busy stays high until the cycle that
// carries the final character of that number.
// Result side: each character appears on o_character with o_last for exactly one
// cycle while o_valid is high. The receiver cannot stall, so nothing is held.
// Text is most significant first: '-' for a negative value, then the digits with
// no leading zeros; o_last marks the final digit. Zero gives a single '0'.
// Sequence: the magnitude is shifted into the cell row one bit per cycle,
// then leading zero digits are shifted out silently, one per cycle, then a
// single step carries the sign (or nothing), then one digit per cycle. The
// final digit comes in the first cycle with busy low, so the next request
// can be taken at the edge that ends that cycle.
// Reset (i_rst_n low, synchronous) returns the controller to idle and drops
// o_valid; the digit cells are cleared at the start of every conversion.
module signed_int_to_decimal_ascii_unit
    import itoa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value,
    output logic        o_valid,
    output logic [7:0]  o_character,
    output logic        o_last
);

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_mag, n_mag;
    logic                    r_neg, n_neg;
    logic [BIT_CNT_W-1:0]    r_bitcnt, n_bitcnt;
    logic [LEFT_W-1:0]       r_left, n_left;
    logic                    r_valid, n_valid;
    logic [7:0]              r_char, n_char;
    logic                    r_last, n_last;

    t_cell_ctrl              w_ctrl;
    logic [NUM_DIGITS:0]     w_carry;
    logic [3:0]              w_digit [NUM_DIGITS];
    logic [VALUE_BITS-1:0]   w_raw;
    logic [VALUE_BITS-1:0]   w_abs;
    logic [3:0]              w_top;

    assign w_raw = i_value[VALUE_BITS-1:0];
    // Two's complement negate; the most negative value maps to its own bit pattern,
    // which read unsigned is the correct magnitude.
    assign w_abs = w_raw[VALUE_BITS-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_top = w_digit[NUM_DIGITS-1];

    assign w_carry[0] = r_mag[VALUE_BITS-1];

    for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
        logic [3:0] w_below;
        if (k == 0) begin : g_bottom
            assign w_below = 4'd0;
        end else begin : g_upper
            assign w_below = w_digit[k-1];
        end
        itoa_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_bit_in   (w_carry[k]),
            .i_digit_in (w_below),
            .o_carry    (w_carry[k+1]),
            .o_digit    (w_digit[k])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_bitcnt = r_bitcnt;
        n_left   = r_left;
        n_valid  = 1'b0;
        n_char   = r_char;
        n_last   = 1'b0;
        w_ctrl   = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_mag        = w_abs;
                    n_neg        = w_raw[VALUE_BITS-1];
                    n_bitcnt     = '0;
                    w_ctrl.clear = 1'b1;
                    n_state      = ST_CONV;
                end
            end
            ST_CONV: begin
                w_ctrl.dabble = 1'b1;
                n_mag         = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bitcnt      = r_bitcnt + 1'b1;
                if (r_bitcnt == BIT_CNT_W'(VALUE_BITS - 1)) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros, but always keep the units digit.
                if (w_top == 4'd0 && r_left != LEFT_W'(1)) begin
                    w_ctrl.shift_up = 1'b1;
                    n_left          = r_left - 1'b1;
                end else begin
                    if (r_neg) begin
                        n_valid = 1'b1;
                        n_char  = CHAR_MINUS;
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                w_ctrl.shift_up = 1'b1;
                n_valid         = 1'b1;
                n_char          = CHAR_ZERO + {4'd0, w_top};
                n_left          = r_left - 1'b1;
                if (r_left == LEFT_W'(1)) begin
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_bitcnt <= n_bitcnt;
        r_left   <= n_left;
        r_char   <= n_char;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // The top digit cell must never overflow: the row is sized for the largest magnitude.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.dabble |-> !w_carry[NUM_DIGITS])
        else $error("digit row overflow during conversion");

    // The final character coincides with the controller returning to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_state == ST_IDLE))
        else $error("last character while conversion still active");

    // A taken request starts conversion with no character in flight.
    a_start_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ST_CONV && !o_valid))
        else $error("request did not start a conversion");

    // The sign is never the final character.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_character == CHAR_MINUS) |-> !o_last)
        else $error("minus sign flagged as last");

endmodule

// File: design/itoa_cell.sv
// One BCD digit cell: shift-add-3 step during conversion, digit shift toward the top on output.
module itoa_cell
    import itoa_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_bit_in,
    input  logic [3:0] i_digit_in,
    output logic       o_carry,
    output logic [3:0] o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Correct before shifting so the digit never passes nine after the shift.
    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctrl.dabble) begin
            n_digit = {w_adj[2:0], i_bit_in};
        end else if (i_ctrl.shift_up) begin
            n_digit = i_digit_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule
